[rtl/orsp_pkg.sv]
// Package for the OPL register stream player: shared types, codes and constants.
// Used by every module of the block; depends on nothing.
package orsp_pkg;

    // Byte position counter width and song length register width.
    localparam int POSITION_BITS = 24;
    localparam int LEN_W         = 24;
    localparam int CMP_W         = (POSITION_BITS > LEN_W) ? POSITION_BITS : LEN_W;

    // Field widths.
    localparam int OP_W    = 2;
    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 2;
    localparam int ADDR_W  = 9;
    localparam int DATA_W  = 8;
    localparam int WAIT_W  = 13;
    localparam int DELAY_W = 16;

    // Wait conversion: blocks = delay * BLOCK_RATE / 1000.
    localparam int BLOCK_RATE = 48000 / 512;
    localparam int RATE_W     = 7;
    localparam int PROD_W     = DELAY_W + RATE_W;
    // floor(x / 1000) = (x * DIV_MUL) >> DIV_SHIFT, exact for x < 2**PROD_W.
    localparam int DIV_SHIFT  = 33;
    localparam int DIV_MUL_W  = 24;
    localparam logic [DIV_MUL_W-1:0] DIV_MUL = 24'd8589935;

    // Command queue between front and back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Input op codes.
    localparam logic [OP_W-1:0] OP_BYTE  = 2'd0;
    localparam logic [OP_W-1:0] OP_START = 2'd1;
    localparam logic [OP_W-1:0] OP_STOP  = 2'd2;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WAIT  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_BANK  = 2'd2;

    // Stream command bytes.
    localparam logic [BYTE_W-1:0] CMD_SHORT   = 8'h00;
    localparam logic [BYTE_W-1:0] CMD_LONG    = 8'h01;
    localparam logic [BYTE_W-1:0] CMD_BANK_LO = 8'h02;
    localparam logic [BYTE_W-1:0] CMD_BANK_HI = 8'h03;
    localparam logic [BYTE_W-1:0] CMD_ESCAPE  = 8'h04;

    // Chip init / silence burst.
    localparam int IDX_W = 4;
    localparam logic [IDX_W-1:0] BURST_FIRST_START = 4'd0;
    localparam logic [IDX_W-1:0] BURST_FIRST_STOP  = 4'd1;
    localparam logic [IDX_W-1:0] BURST_LAST        = 4'd10;
    localparam logic [ADDR_W-1:0] REG_TEST   = 9'h001;
    localparam logic [ADDR_W-1:0] REG_RHYTHM = 9'h0BD;
    localparam logic [ADDR_W-1:0] REG_KEYON  = 9'h0B0;
    localparam logic [DATA_W-1:0] TEST_VALUE = 8'h20;

    // Parser phase, one-hot.
    typedef enum logic [5:0] {
        PH_CMD     = 6'b000001,
        PH_SHORT   = 6'b000010,
        PH_LONG_LO = 6'b000100,
        PH_LONG_HI = 6'b001000,
        PH_ESC     = 6'b010000,
        PH_DATA    = 6'b100000
    } t_phase;

    // What the back end does with a queued command.
    typedef enum logic [1:0] {
        JOB_SINGLE = 2'd0,
        JOB_START  = 2'd1,
        JOB_STOP   = 2'd2
    } t_job;

    typedef struct packed {
        t_job                job;
        logic [KIND_W-1:0]   kind;
        logic [ADDR_W-1:0]   addr;
        logic [DATA_W-1:0]   data;
        logic [PROD_W-1:0]   prod;   // delay * BLOCK_RATE, waits only
        logic                loop_back;
    } t_entry;

    // Register address of one step of the init / silence burst.
    function automatic logic [ADDR_W-1:0] burst_addr(input logic [IDX_W-1:0] idx);
        logic [ADDR_W-1:0] a;
        case (idx)
            BURST_FIRST_START: a = REG_TEST;
            BURST_FIRST_STOP:  a = REG_RHYTHM;
            default:           a = REG_KEYON + ADDR_W'(idx - 4'd2);
        endcase
        return a;
    endfunction

endpackage

[rtl/orsp_queue.sv]
// Short command queue between the parser front end and the result back end.
// Depends on orsp_pkg.
module orsp_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  orsp_pkg::t_entry i_entry,
    input  logic            i_pop,
    output orsp_pkg::t_entry o_head,
    output logic            o_empty,
    output logic            o_full
);

    orsp_pkg::t_entry r_mem [orsp_pkg::QUEUE_DEPTH];
    logic [orsp_pkg::QPTR_W-1:0] r_wr, r_rd;
    logic [orsp_pkg::QCNT_W-1:0] r_count, n_count;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == orsp_pkg::QCNT_W'(orsp_pkg::QUEUE_DEPTH));
    assign o_head  = r_mem[r_rd];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= orsp_pkg::QCNT_W'(orsp_pkg::QUEUE_DEPTH))
        else $error("command queue count out of range");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty command queue");
    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_wr == r_rd))
        else $error("queue pointers disagree with empty count");
`endif

endmodule

[rtl/orsp_front.sv]
// Front end: accepts stream items, parses command bytes, tracks position and loop.
// Pushes one command per result-producing item into the queue. Depends on orsp_pkg.
module orsp_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic [orsp_pkg::OP_W-1:0]       i_op,
    input  logic [orsp_pkg::BYTE_W-1:0]     i_byte,
    input  logic                            i_full,
    input  logic [orsp_pkg::LEN_W-1:0]      i_song_length,
    output logic                            o_ready,
    output logic                            o_push,
    output orsp_pkg::t_entry                o_entry
);

    localparam logic [orsp_pkg::POSITION_BITS-1:0] POS_MAX = '1;

    logic                                 r_playing, n_playing;
    orsp_pkg::t_phase                     r_phase, n_phase;
    logic                                 r_bank, n_bank;
    logic [orsp_pkg::BYTE_W-1:0]          r_held, n_held;
    logic [orsp_pkg::BYTE_W-1:0]          r_low, n_low;
    logic [orsp_pkg::POSITION_BITS-1:0]   r_pos, n_pos;

    logic                                 accept;
    logic                                 done;
    logic                                 at_end;
    logic [orsp_pkg::POSITION_BITS-1:0]   pos_inc;
    logic [orsp_pkg::DELAY_W-1:0]         delay;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;
    assign pos_inc = (r_pos != POS_MAX) ? r_pos + 1'b1 : r_pos;
    assign at_end  = orsp_pkg::CMP_W'(pos_inc) >= orsp_pkg::CMP_W'(i_song_length);

    always_comb begin
        n_playing = r_playing;
        n_phase   = r_phase;
        n_bank    = r_bank;
        n_held    = r_held;
        n_low     = r_low;
        n_pos     = r_pos;
        o_push    = 1'b0;
        o_entry   = '0;
        done      = 1'b0;
        delay     = '0;
        if (accept) begin
            case (i_op)
                orsp_pkg::OP_START: begin
                    o_push        = 1'b1;
                    o_entry.job   = orsp_pkg::JOB_START;
                    n_playing     = 1'b1;
                    n_phase       = orsp_pkg::PH_CMD;
                    n_bank        = 1'b0;
                    n_pos         = '0;
                end
                orsp_pkg::OP_STOP: begin
                    o_push        = 1'b1;
                    o_entry.job   = orsp_pkg::JOB_STOP;
                    n_playing     = 1'b0;
                end
                orsp_pkg::OP_BYTE: begin
                    if (r_playing) begin
                        n_pos = pos_inc;
                        case (r_phase)
                            orsp_pkg::PH_SHORT: begin
                                n_phase      = orsp_pkg::PH_CMD;
                                done         = 1'b1;
                                delay        = orsp_pkg::DELAY_W'(i_byte);
                                o_entry.kind = orsp_pkg::KIND_WAIT;
                            end
                            orsp_pkg::PH_LONG_LO: begin
                                n_low   = i_byte;
                                n_phase = orsp_pkg::PH_LONG_HI;
                            end
                            orsp_pkg::PH_LONG_HI: begin
                                n_phase      = orsp_pkg::PH_CMD;
                                done         = 1'b1;
                                delay        = {i_byte, r_low};
                                o_entry.kind = orsp_pkg::KIND_WAIT;
                            end
                            orsp_pkg::PH_ESC: begin
                                n_held  = i_byte;
                                n_phase = orsp_pkg::PH_DATA;
                            end
                            orsp_pkg::PH_DATA: begin
                                n_phase      = orsp_pkg::PH_CMD;
                                done         = 1'b1;
                                o_entry.kind = orsp_pkg::KIND_WRITE;
                                o_entry.addr = {r_bank, r_held};
                                o_entry.data = i_byte;
                            end
                            default: begin
                                // Expecting a command byte.
                                case (i_byte)
                                    orsp_pkg::CMD_SHORT:   n_phase = orsp_pkg::PH_SHORT;
                                    orsp_pkg::CMD_LONG:    n_phase = orsp_pkg::PH_LONG_LO;
                                    orsp_pkg::CMD_BANK_LO,
                                    orsp_pkg::CMD_BANK_HI: begin
                                        n_phase      = orsp_pkg::PH_CMD;
                                        n_bank       = i_byte[0];
                                        done         = 1'b1;
                                        o_entry.kind = orsp_pkg::KIND_BANK;
                                    end
                                    orsp_pkg::CMD_ESCAPE:  n_phase = orsp_pkg::PH_ESC;
                                    default: begin
                                        n_held  = i_byte;
                                        n_phase = orsp_pkg::PH_DATA;
                                    end
                                endcase
                            end
                        endcase
                        if (done) begin
                            o_push            = 1'b1;
                            o_entry.job       = orsp_pkg::JOB_SINGLE;
                            o_entry.loop_back = at_end;
                            o_entry.prod      = orsp_pkg::PROD_W'(delay)
                                              * orsp_pkg::PROD_W'(orsp_pkg::BLOCK_RATE);
                            if (at_end) begin
                                n_pos = '0;
                            end
                        end
                    end
                end
                default: begin
                    // Unused op: drop.
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_playing <= 1'b0;
            r_phase   <= orsp_pkg::PH_CMD;
            r_bank    <= 1'b0;
            r_held    <= '0;
            r_low     <= '0;
            r_pos     <= '0;
        end else begin
            r_playing <= n_playing;
            r_phase   <= n_phase;
            r_bank    <= n_bank;
            r_held    <= n_held;
            r_low     <= n_low;
            r_pos     <= n_pos;
        end
    end

`ifndef SYNTHESIS
    a_start_plays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_op == orsp_pkg::OP_START) |=> (r_playing && r_pos == '0))
        else $error("start did not arm playback");
    a_stop_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_op == orsp_pkg::OP_STOP) |=> !r_playing)
        else $error("stop did not halt playback");
    a_push_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> !i_full)
        else $error("push into full command queue");
`endif

endmodule

[rtl/orsp_back.sv]
// Back end: pops queued commands, expands init/silence bursts, scales waits,
// and holds the result in the output register. Depends on orsp_pkg.
module orsp_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  orsp_pkg::t_entry                i_head,
    input  logic                            i_empty,
    output logic                            o_pop,
    input  logic                            i_ready,
    output logic                            o_valid,
    output logic [orsp_pkg::KIND_W-1:0]     o_kind,
    output logic [orsp_pkg::ADDR_W-1:0]     o_addr,
    output logic [orsp_pkg::DATA_W-1:0]     o_data,
    output logic [orsp_pkg::WAIT_W-1:0]     o_wait,
    output logic                            o_loop_back,
    output logic                            o_last
);

    localparam int MUL_W = orsp_pkg::PROD_W + orsp_pkg::DIV_MUL_W;

    logic                               r_valid;
    logic                               r_in_burst, n_in_burst;
    logic [orsp_pkg::IDX_W-1:0]         r_idx, n_idx;
    logic [orsp_pkg::KIND_W-1:0]        r_kind, n_kind;
    logic [orsp_pkg::ADDR_W-1:0]        r_addr, n_addr;
    logic [orsp_pkg::DATA_W-1:0]        r_data, n_data;
    logic [orsp_pkg::WAIT_W-1:0]        r_wait, n_wait;
    logic                               r_loop, n_loop;
    logic                               r_last, n_last;

    logic                               advance;
    logic [orsp_pkg::IDX_W-1:0]         eff_idx;
    logic [MUL_W-1:0]                   scaled;

    assign advance = !r_valid || i_ready;
    assign scaled  = MUL_W'(i_head.prod) * MUL_W'(orsp_pkg::DIV_MUL);

    always_comb begin
        if (r_in_burst) begin
            eff_idx = r_idx;
        end else if (i_head.job == orsp_pkg::JOB_START) begin
            eff_idx = orsp_pkg::BURST_FIRST_START;
        end else begin
            eff_idx = orsp_pkg::BURST_FIRST_STOP;
        end
    end

    always_comb begin
        o_pop      = 1'b0;
        n_in_burst = r_in_burst;
        n_idx      = r_idx;
        n_kind     = i_head.kind;
        n_addr     = i_head.addr;
        n_data     = i_head.data;
        n_wait     = scaled[orsp_pkg::DIV_SHIFT +: orsp_pkg::WAIT_W];
        n_loop     = i_head.loop_back;
        n_last     = 1'b1;
        case (i_head.job)
            orsp_pkg::JOB_START,
            orsp_pkg::JOB_STOP: begin
                n_kind = orsp_pkg::KIND_WRITE;
                n_addr = orsp_pkg::burst_addr(eff_idx);
                n_data = (eff_idx == orsp_pkg::BURST_FIRST_START) ?
                         orsp_pkg::TEST_VALUE : '0;
                n_wait = '0;
                n_loop = 1'b0;
                n_last = (eff_idx == orsp_pkg::BURST_LAST);
                if (advance && !i_empty) begin
                    if (n_last) begin
                        o_pop      = 1'b1;
                        n_in_burst = 1'b0;
                    end else begin
                        n_in_burst = 1'b1;
                        n_idx      = eff_idx + 1'b1;
                    end
                end
            end
            default: begin
                o_pop = advance && !i_empty;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_in_burst <= 1'b0;
            r_idx      <= '0;
        end else begin
            r_in_burst <= n_in_burst;
            r_idx      <= n_idx;
            if (advance) begin
                r_valid <= !i_empty;
            end
        end
    end

    // Payload: load on advance, hold while the receiver stalls.
    always_ff @(posedge i_clk) begin
        if (advance && !i_empty) begin
            r_kind <= n_kind;
            r_addr <= n_addr;
            r_data <= n_data;
            r_wait <= n_wait;
            r_loop <= n_loop;
            r_last <= n_last;
        end
    end

    assign o_valid     = r_valid;
    assign o_kind      = r_kind;
    assign o_addr      = r_addr;
    assign o_data      = r_data;
    assign o_wait      = r_wait;
    assign o_loop_back = r_loop;
    assign o_last      = r_last;

`ifndef SYNTHESIS
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_burst |-> (r_idx <= orsp_pkg::BURST_LAST))
        else $error("burst index out of range");
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_kind != orsp_pkg::KIND_WRITE) |-> r_last)
        else $error("wait or bank result not marked last");
    a_wait_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_kind != orsp_pkg::KIND_WAIT) |-> (r_wait == '0))
        else $error("wait count on a non-wait result");
`endif

endmodule

[rtl/opl_register_stream_player_top.sv]
// Top level of the OPL register stream player: ports, song length register,
// and the front end / command queue / back end chain. Depends on orsp_pkg.
//
// Usage:
//  - Slave stream: tuser carries the op (song byte, start, stop), tdata the
//    song byte. One item is taken per cycle while the command queue has room.
//  - Master stream: one result per transfer; tuser is the kind (register
//    write, wait, bank change), tdata carries address, data, wait blocks and
//    the loop flag, tlast marks the final result of an input item.
//  - Config channel: writes the 24-bit song length; always ready. Write it
//    only while the block is idle.
//  - Result path: a completed command is registered in the command queue, then
//    in the back end's output register, which drives tvalid.
//  - Throughput: one song byte per cycle while the queue has room. A start op
//    expands into 11 writes and a stop op into 10, one per cycle from the burst
//    counter while tready is high; the four-entry command queue absorbs input.
//  - Reset: playback stopped, parser expects a command byte, low bank,
//    position zero, song length one, no result pending.
//  - Receiver stall: the output register holds its result; the queue fills,
//    then tready drops on the slave side until space frees up.
module opl_register_stream_player_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Song stream in.
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] song_byte
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] op
    // Result stream out.
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [8:0] reg_address, [16:9] reg_data,
                                          // [29:17] wait_blocks, [30] loop_back
    output logic [1:0]  o_m_axis_tuser,   // [1:0] kind
    output logic        o_m_axis_tlast,
    // Song length write.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [23:0] i_cfg_data
);

    logic [orsp_pkg::LEN_W-1:0]     r_song_length;

    orsp_pkg::t_entry               push_entry;
    orsp_pkg::t_entry               head;
    logic                           push;
    logic                           pop;
    logic                           q_empty;
    logic                           q_full;

    logic [orsp_pkg::KIND_W-1:0]    res_kind;
    logic [orsp_pkg::ADDR_W-1:0]    res_addr;
    logic [orsp_pkg::DATA_W-1:0]    res_data;
    logic [orsp_pkg::WAIT_W-1:0]    res_wait;
    logic                           res_loop;

    // Song length register; write config only while idle (not enforced).
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_song_length <= orsp_pkg::LEN_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_song_length <= i_cfg_data;
        end
    end

    orsp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_s_axis_tvalid),
        .i_op          (i_s_axis_tuser),
        .i_byte        (i_s_axis_tdata),
        .i_full        (q_full),
        .i_song_length (r_song_length),
        .o_ready       (o_s_axis_tready),
        .o_push        (push),
        .o_entry       (push_entry)
    );

    orsp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    orsp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_empty     (q_empty),
        .o_pop       (pop),
        .i_ready     (i_m_axis_tready),
        .o_valid     (o_m_axis_tvalid),
        .o_kind      (res_kind),
        .o_addr      (res_addr),
        .o_data      (res_data),
        .o_wait      (res_wait),
        .o_loop_back (res_loop),
        .o_last      (o_m_axis_tlast)
    );

    // Pack the result fields, lowest first, pad to whole bytes.
    assign o_m_axis_tdata = {1'b0, res_loop, res_wait, res_data, res_addr};
    assign o_m_axis_tuser = res_kind;

endmodule

[verif/orsp_stream_checker.sv]
`timescale 1ns / 100ps
// Result checker for the OPL register stream player: watches the song, result
// and song length channels, decodes the song stream itself and compares every
// result transfer. Depends on orsp_pkg.
module orsp_stream_checker
    import orsp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_valid,
    input  logic                i_s_ready,
    input  logic [BYTE_W-1:0]   i_s_data,
    input  logic [OP_W-1:0]     i_s_user,
    input  logic                i_m_valid,
    input  logic                i_m_ready,
    input  logic [31:0]         i_m_data,
    input  logic [KIND_W-1:0]   i_m_user,
    input  logic                i_m_last,
    input  logic                i_cfg_valid,
    input  logic                i_cfg_ready,
    input  logic [LEN_W-1:0]    i_cfg_data,
    output int                  o_mismatch_count,
    output int                  o_due_count
);

    localparam int KEYON_REGS    = 9;
    localparam int MS_PER_SECOND = 1000;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
        logic [WAIT_W-1:0] blocks;
        logic              loop_back;
        logic              last;
    } t_chip_event;

    // Decoder state, mirrors the player.
    logic                     playing;
    t_phase                   phase;
    logic                     bank_hi;
    logic [BYTE_W-1:0]        held_reg;
    logic [BYTE_W-1:0]        delay_lo;
    logic [POSITION_BITS-1:0] byte_pos;
    logic [LEN_W-1:0]         loop_length;

    t_chip_event item_events[$];   // events of the item being decoded
    t_chip_event due_events[$];    // events still owed by the block
    int          mismatch_count;

    function automatic void add_event(input logic [KIND_W-1:0] kind,
                                      input logic [ADDR_W-1:0] addr,
                                      input logic [DATA_W-1:0] data,
                                      input logic [WAIT_W-1:0] blocks,
                                      input logic              loop_back);
        t_chip_event ev;
        ev.kind      = kind;
        ev.addr      = addr;
        ev.data      = data;
        ev.blocks    = blocks;
        ev.loop_back = loop_back;
        ev.last      = 1'b0;
        item_events.insert(item_events.size(), ev);
    endfunction

    function automatic void add_silence();
        add_event(KIND_WRITE, REG_RHYTHM, '0, '0, 1'b0);
        for (int i = 0; i < KEYON_REGS; i++) begin
            add_event(KIND_WRITE, REG_KEYON + ADDR_W'(i), '0, '0, 1'b0);
        end
    endfunction

    // Close a command; wrap the position once the song length is reached.
    function automatic logic close_command();
        if (CMP_W'(byte_pos) >= CMP_W'(loop_length)) begin
            byte_pos = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic [WAIT_W-1:0] delay_to_blocks(input logic [DELAY_W-1:0] delay);
        logic [31:0] scaled;
        scaled = 32'(delay) * 32'(BLOCK_RATE);
        return WAIT_W'(scaled / 32'(MS_PER_SECOND));
    endfunction

    function automatic void decode_song_item(input logic [OP_W-1:0] op,
                                             input logic [BYTE_W-1:0] b);
        logic lp;
        t_chip_event ev;
        item_events.delete();
        if (op == OP_START) begin
            add_event(KIND_WRITE, REG_TEST, TEST_VALUE, '0, 1'b0);
            add_silence();
            playing  = 1'b1;
            phase    = PH_CMD;
            bank_hi  = 1'b0;
            byte_pos = '0;
        end else if (op == OP_STOP) begin
            add_silence();
            playing = 1'b0;
        end else if (op == OP_BYTE && playing) begin
            if (byte_pos != '1) byte_pos = byte_pos + 1'b1;
            case (phase)
                PH_SHORT: begin
                    phase = PH_CMD;
                    lp = close_command();
                    add_event(KIND_WAIT, '0, '0, delay_to_blocks(DELAY_W'(b)), lp);
                end
                PH_LONG_LO: begin
                    delay_lo = b;
                    phase    = PH_LONG_HI;
                end
                PH_LONG_HI: begin
                    phase = PH_CMD;
                    lp = close_command();
                    add_event(KIND_WAIT, '0, '0, delay_to_blocks({b, delay_lo}), lp);
                end
                PH_ESC: begin
                    held_reg = b;
                    phase    = PH_DATA;
                end
                PH_DATA: begin
                    phase = PH_CMD;
                    lp = close_command();
                    add_event(KIND_WRITE, {bank_hi, held_reg}, b, '0, lp);
                end
                default: begin
                    phase = PH_CMD;
                    if (b == CMD_SHORT) begin
                        phase = PH_SHORT;
                    end else if (b == CMD_LONG) begin
                        phase = PH_LONG_LO;
                    end else if (b == CMD_BANK_LO || b == CMD_BANK_HI) begin
                        bank_hi = b[0];
                        lp = close_command();
                        add_event(KIND_BANK, '0, '0, '0, lp);
                    end else if (b == CMD_ESCAPE) begin
                        phase = PH_ESC;
                    end else begin
                        held_reg = b;
                        phase    = PH_DATA;
                    end
                end
            endcase
        end
        for (int i = 0; i < item_events.size(); i++) begin
            ev = item_events[i];
            ev.last = (i == item_events.size() - 1);
            due_events.insert(due_events.size(), ev);
        end
    endfunction

    always @(posedge i_clk) begin
        t_chip_event got;
        t_chip_event want;
        if (!i_rst_n) begin
            playing        = 1'b0;
            phase          = PH_CMD;
            bank_hi        = 1'b0;
            held_reg       = '0;
            delay_lo       = '0;
            byte_pos       = '0;
            loop_length    = LEN_W'(1);
            mismatch_count = 0;
            due_events.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) loop_length = i_cfg_data;

            if (i_m_valid && i_m_ready) begin
                got.kind      = i_m_user;
                got.addr      = i_m_data[8:0];
                got.data      = i_m_data[16:9];
                got.blocks    = i_m_data[29:17];
                got.loop_back = i_m_data[30];
                got.last      = i_m_last;
                if (due_events.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected result: expected none, actual kind=%0d",
                             $time, got.kind, " addr=%h data=%h blocks=%0d loop=%b last=%b",
                             got.addr, got.data, got.blocks, got.loop_back, got.last);
                end else begin
                    want = due_events.pop_front();
                    if (got.kind != want.kind || got.addr != want.addr ||
                        got.data != want.data || got.blocks != want.blocks ||
                        got.loop_back != want.loop_back || got.last != want.last) begin
                        mismatch_count++;
                        $display("%0t: result mismatch: expected kind=%0d addr=%h data=%h",
                                 $time, want.kind, want.addr, want.data,
                                 " blocks=%0d loop=%b last=%b, actual kind=%0d",
                                 want.blocks, want.loop_back, want.last, got.kind,
                                 " addr=%h data=%h blocks=%0d loop=%b last=%b",
                                 got.addr, got.data, got.blocks, got.loop_back, got.last);
                    end
                end
            end

            if (i_s_valid && i_s_ready) decode_song_item(i_s_user, i_s_data);
        end
        o_mismatch_count <= mismatch_count;
        o_due_count      <= due_events.size();
    end

endmodule

[verif/tb_opl_register_stream_player_top.sv]
`timescale 1ns / 100ps
// Testbench top for the OPL register stream player: drives song items, song
// length writes and result back-pressure, and gives the verdict.
// Depends on orsp_pkg, opl_register_stream_player_top and orsp_stream_checker.
module tb_opl_register_stream_player_top;
    import orsp_pkg::*;

    // The one op code the block ignores.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam int MAX_GAP          = 18;
    localparam int SINK_HOLD_CYCLES = 300;   // long receiver stall to fill the queue
    localparam int SETTLE_CYCLES    = 8;     // idle time after the results drain
    localparam int WATCHDOG_LIMIT   = 3000;  // cycles without any transfer
    localparam logic [LEN_W-1:0] LEN_MAX = '1;

    logic i_clk;
    logic i_rst_n = 1'b0;

    // Song stream into the block.
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [BYTE_W-1:0] s_data  = '0;
    logic [OP_W-1:0]   s_user  = OP_BYTE;

    // Result stream out of the block.
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [31:0]       m_data;
    logic [KIND_W-1:0] m_user;
    logic              m_last;

    // Song length writes.
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [LEN_W-1:0]  cfg_data  = '0;

    int mismatch_count;
    int due_count;
    int idle_cycles = 0;

    // Stimulus shaping for the sender and the receiver.
    bit song_on   = 1'b0;   // sender's own view of playback, for well-formed streams
    bit src_fast  = 1'b0;   // sender offers back to back while set
    bit sink_fast = 1'b0;   // receiver takes back to back while set
    bit sink_hold = 1'b0;   // asks the receiver for one long stall

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    opl_register_stream_player_top u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),    // [7:0] song_byte
        .i_s_axis_tuser  (s_user),    // [1:0] op
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),    // [8:0] reg_address, [16:9] reg_data,
                                      // [29:17] wait_blocks, [30] loop_back
        .o_m_axis_tuser  (m_user),    // [1:0] kind
        .o_m_axis_tlast  (m_last),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    orsp_stream_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_s_valid        (s_valid),
        .i_s_ready        (s_ready),
        .i_s_data         (s_data),
        .i_s_user         (s_user),
        .i_m_valid        (m_valid),
        .i_m_ready        (m_ready),
        .i_m_data         (m_data),
        .i_m_user         (m_user),
        .i_m_last         (m_last),
        .i_cfg_valid      (cfg_valid),
        .i_cfg_ready      (cfg_ready),
        .i_cfg_data       (cfg_data),
        .o_mismatch_count (mismatch_count),
        .o_due_count      (due_count)
    );

    // Abort when no channel has moved a transfer for too long.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("tb_opl_register_stream_player_top: errors");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Receiver: stall a random number of cycles before each result, sometimes
    // run back to back, and honor one long hold when the sender asks for it.
    initial begin
        int stall;
        forever begin
            if (sink_hold) begin
                m_ready <= 1'b0;
                repeat (SINK_HOLD_CYCLES) @(posedge i_clk);
                sink_hold = 1'b0;
            end
            if ($urandom_range(0, 15) == 0) sink_fast = !sink_fast;
            stall = sink_fast ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_ready <= 1'b1;
            do @(posedge i_clk); while (!m_valid);
        end
    end

    // Offer one item after a random gap and hold it until the transfer.
    // Keep tvalid high across back-to-back items.
    task automatic send_item(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] b);
        int gap;
        gap = src_fast ? 0 : $urandom_range(0, MAX_GAP);
        if ($urandom_range(0, 15) == 0) src_fast = !src_fast;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        s_user  <= op;
        do @(posedge i_clk); while (!s_ready);
        if (op == OP_START) song_on = 1'b1;
        else if (op == OP_STOP) song_on = 1'b0;
    endtask

    // Drop tvalid and wait until every owed result has come out.
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge i_clk);
        wait (due_count == 0);
    endtask

    // Idle the block fully, then change the song length.
    task automatic write_song_length(input logic [LEN_W-1:0] len);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data  <= len;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Mostly well-formed commands with random content, plus stray bytes,
    // start/stop ops and unused ops. Ignored items do not advance the count.
    task automatic play_random(input int count, input bit squeeze);
        int done;
        int pick;
        bit held;
        bit paused;
        done   = 0;
        held   = 1'b0;
        paused = 1'b0;
        while (done < count) begin
            // Stall the receiver while the sender streams, to fill the queue.
            if (squeeze && !held && done >= count / 2) begin
                held      = 1'b1;
                sink_hold = 1'b1;
                src_fast  = 1'b1;
            end
            // Then pause the sender until every result is out.
            if (squeeze && !paused && done >= (3 * count) / 4) begin
                paused = 1'b1;
                drain_results();
            end
            pick = $urandom_range(0, 99);
            if (!song_on) begin
                if (pick < 75) begin
                    send_item(OP_START, BYTE_W'($urandom_range(0, 255)));
                    done++;
                end else if (pick < 85) begin
                    send_item(OP_STOP, BYTE_W'($urandom_range(0, 255)));
                    done++;
                end else if (pick < 93) begin
                    send_item(OP_BYTE, BYTE_W'($urandom_range(0, 255)));
                end else begin
                    send_item(OP_UNUSED, BYTE_W'($urandom_range(0, 255)));
                end
            end else if (pick < 4) begin
                send_item(OP_START, BYTE_W'($urandom_range(0, 255)));
                done++;
            end else if (pick < 8) begin
                send_item(OP_STOP, BYTE_W'($urandom_range(0, 255)));
                done++;
            end else if (pick < 10) begin
                send_item(OP_UNUSED, BYTE_W'($urandom_range(0, 255)));
            end else if (pick < 16) begin
                // Stray byte: knocks the command framing out of step.
                send_item(OP_BYTE, BYTE_W'($urandom_range(0, 255)));
                done++;
            end else begin
                case ($urandom_range(0, 9))
                    0: begin
                        send_item(OP_BYTE, CMD_SHORT);
                        send_item(OP_BYTE, BYTE_W'($urandom_range(0, 255)));
                        done += 2;
                    end
                    1: begin
                        send_item(OP_BYTE, CMD_LONG);
                        send_item(OP_BYTE, BYTE_W'($urandom_range(0, 255)));
                        send_item(OP_BYTE, BYTE_W'($urandom_range(0, 255)));
                        done += 3;
                    end
                    2: begin
                        send_item(OP_BYTE, $urandom_range(0, 1) ? CMD_BANK_HI : CMD_BANK_LO);
                        done += 1;
                    end
                    3: begin
                        send_item(OP_BYTE, CMD_ESCAPE);
                        send_item(OP_BYTE, BYTE_W'($urandom_range(0, 255)));
                        send_item(OP_BYTE, BYTE_W'($urandom_range(0, 255)));
                        done += 3;
                    end
                    default: begin
                        send_item(OP_BYTE, BYTE_W'($urandom_range(CMD_ESCAPE + 1, 255)));
                        send_item(OP_BYTE, BYTE_W'($urandom_range(0, 255)));
                        done += 2;
                    end
                endcase
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: longest song so nothing wraps here.
        write_song_length(LEN_MAX);
        send_item(OP_BYTE,   8'h55);          // stopped: drop silently
        send_item(OP_UNUSED, 8'hFF);          // unused op: no result
        send_item(OP_STOP,   8'h00);          // silence even when stopped
        send_item(OP_START,  8'h00);          // chip init burst
        send_item(OP_BYTE,   CMD_SHORT);      // longest short delay
        send_item(OP_BYTE,   8'hFF);
        send_item(OP_BYTE,   CMD_SHORT);      // zero delay still waits
        send_item(OP_BYTE,   8'h00);
        send_item(OP_BYTE,   CMD_LONG);       // longest long delay
        send_item(OP_BYTE,   8'hFF);
        send_item(OP_BYTE,   8'hFF);
        send_item(OP_BYTE,   CMD_LONG);       // zero long delay
        send_item(OP_BYTE,   8'h00);
        send_item(OP_BYTE,   8'h00);
        send_item(OP_BYTE,   CMD_BANK_HI);
        send_item(OP_BYTE,   CMD_ESCAPE);     // escaped bank code as a register
        send_item(OP_BYTE,   CMD_BANK_LO);
        send_item(OP_BYTE,   8'hAB);
        send_item(OP_BYTE,   8'hFF);          // top register, high bank
        send_item(OP_UNUSED, 8'h00);          // unused op between register and data
        send_item(OP_BYTE,   8'h00);
        send_item(OP_BYTE,   CMD_BANK_LO);
        send_item(OP_BYTE,   8'h05);          // lowest plain register
        send_item(OP_BYTE,   8'hFF);

        // Random phases across song lengths, extremes included.
        write_song_length(LEN_W'(5));
        play_random(100, 1'b1);
        write_song_length(LEN_W'(1));
        play_random(60, 1'b0);
        write_song_length(LEN_W'(0));         // every command wraps
        play_random(40, 1'b0);
        write_song_length(LEN_W'(300));
        play_random(80, 1'b0);
        write_song_length(LEN_MAX);
        play_random(30, 1'b0);

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && due_count == 0) begin
            $display("tb_opl_register_stream_player_top: clean");
        end else begin
            $display("tb_opl_register_stream_player_top: errors");
        end
        $finish;
    end

endmodule

[files.f]
rtl/orsp_pkg.sv
rtl/orsp_queue.sv
rtl/orsp_front.sv
rtl/orsp_back.sv
rtl/opl_register_stream_player_top.sv
verif/orsp_stream_checker.sv
verif/tb_opl_register_stream_player_top.sv
